/* design/u8dv_pkg.sv */
// Package for the UTF-8 stream decode and validate unit.
// Holds the transaction types, field codes and sizing constants; no dependencies.
package u8dv_pkg;

  // Result queue depth, a power of two of at least 2
  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [20:0] MaxScalar     = 21'h10FFFF;
  localparam logic [20:0] SurrogateLow  = 21'h00D800;
  localparam logic [20:0] SurrogateHigh = 21'h00DFFF;
  localparam logic [20:0] MinTwoByte    = 21'h000080;
  localparam logic [20:0] MinThreeByte  = 21'h000800;
  localparam logic [20:0] MinFourByte   = 21'h010000;

  localparam logic KindCodePoint = 1'b0;
  localparam logic KindVerdict   = 1'b1;

  localparam logic [1:0] VerdictValid     = 2'd0;
  localparam logic [1:0] VerdictTruncated = 2'd1;
  localparam logic [1:0] VerdictInvalid   = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [20:0] code_point;
    logic [1:0]  verdict;
    logic [1:0]  missing_bytes;
    logic        run_last;
  } out_item_t;

  // Results produced by one byte, in order: res0 then res1
  typedef struct packed {
    logic [1:0] num;
    out_item_t  res0;
    out_item_t  res1;
  } step_res_t;

endpackage

/* design/u8dv_step.sv */
// Decode step of the UTF-8 stream unit: sequence state registers and the
// per-byte decode, check and verdict logic. Depends on u8dv_pkg.
module u8dv_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  u8dv_pkg::in_item_t item_i,
  output u8dv_pkg::step_res_t res_o
);

  logic [1:0]  pend_q, pend_d;
  logic [2:0]  seq_len_q, seq_len_d;
  logic [20:0] part_q, part_d;
  logic        err_q, err_d;

  logic [7:0]  b;
  logic [2:0]  lead_len;
  logic [7:0]  lead_mask;
  logic [20:0] cont_val;
  logic [20:0] min_val;
  logic        cp_bad;
  u8dv_pkg::out_item_t cp_res, vd_res;

  assign b = item_i.in_byte;

  always_comb begin
    if (b[7] == 1'b0) begin
      lead_len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  assign lead_mask = 8'h7F >> lead_len;
  assign cont_val  = {part_q[14:0], b[5:0]};

  always_comb begin
    unique case (seq_len_q)
      3'd2:    min_val = u8dv_pkg::MinTwoByte;
      3'd3:    min_val = u8dv_pkg::MinThreeByte;
      default: min_val = u8dv_pkg::MinFourByte;
    endcase
  end

  assign cp_bad = (cont_val > u8dv_pkg::MaxScalar) ||
                  ((cont_val >= u8dv_pkg::SurrogateLow) &&
                   (cont_val <= u8dv_pkg::SurrogateHigh)) ||
                  (cont_val < min_val);

  always_comb begin
    pend_d    = pend_q;
    seq_len_d = seq_len_q;
    part_d    = part_q;
    err_d     = err_q;
    cp_res    = '0;
    vd_res    = '0;
    res_o     = '0;

    cp_res.kind = u8dv_pkg::KindCodePoint;

    if (!err_q) begin
      if (pend_q == 2'd0) begin
        if (lead_len == 3'd1) begin
          cp_res.code_point = {13'd0, b};
          res_o.num = 2'd1;
        end else if (lead_len == 3'd0) begin
          err_d     = 1'b1;
          pend_d    = 2'd0;
          seq_len_d = 3'd0;
          part_d    = '0;
        end else begin
          seq_len_d = lead_len;
          pend_d    = 2'(lead_len - 3'd1);
          part_d    = {13'd0, b & lead_mask};
        end
      end else if (b[7:6] != 2'b10) begin
        // broken sequence; this byte is not taken as a new lead
        err_d     = 1'b1;
        pend_d    = 2'd0;
        seq_len_d = 3'd0;
        part_d    = '0;
      end else begin
        part_d = cont_val;
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          if (cp_bad) begin
            err_d = 1'b1;
          end else begin
            cp_res.code_point = cont_val;
            res_o.num = 2'd1;
          end
          pend_d    = 2'd0;
          seq_len_d = 3'd0;
          part_d    = '0;
        end
      end
    end

    vd_res.kind     = u8dv_pkg::KindVerdict;
    vd_res.run_last = 1'b1;
    if (err_d) begin
      vd_res.verdict = u8dv_pkg::VerdictInvalid;
    end else if (pend_d != 2'd0) begin
      vd_res.verdict       = u8dv_pkg::VerdictTruncated;
      vd_res.missing_bytes = pend_d;
    end else begin
      vd_res.verdict = u8dv_pkg::VerdictValid;
    end

    if (item_i.end_of_string) begin
      if (res_o.num == 2'd1) begin
        res_o.res0 = cp_res;
        res_o.res1 = vd_res;
        res_o.num  = 2'd2;
      end else begin
        res_o.res0 = vd_res;
        res_o.num  = 2'd1;
      end
      // back to reset for the next string
      pend_d    = 2'd0;
      seq_len_d = 3'd0;
      part_d    = '0;
      err_d     = 1'b0;
    end else begin
      cp_res.run_last = 1'b1;
      res_o.res0      = cp_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 2'd0;
      seq_len_q <= 3'd0;
      part_q    <= '0;
      err_q     <= 1'b0;
    end else if (fire_i) begin
      pend_q    <= pend_d;
      seq_len_q <= seq_len_d;
      part_q    <= part_d;
      err_q     <= err_d;
    end
  end

endmodule

/* design/u8dv_fifo.sv */
// Result queue of the UTF-8 stream unit: flip-flop FIFO that takes up to
// two entries per cycle, delivers one unless stalled; uses u8dv_pkg.
module u8dv_fifo #(
  parameter int unsigned Depth = u8dv_pkg::FifoDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_num_i,
  input  u8dv_pkg::out_item_t push0_i,
  input  u8dv_pkg::out_item_t push1_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output u8dv_pkg::out_item_t out_item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  u8dv_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d, tail_nx;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign tail_nx     = tail_q + PtrW'(1);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[head_q];
  assign room2_o     = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    head_d = pop ? head_q + PtrW'(1) : head_q;
    tail_d = tail_q + PtrW'(push_num_i);
    cnt_d  = cnt_q + CntW'(push_num_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      mem_q[tail_q] <= push0_i;
    end
    if (push_num_i == 2'd2) begin
      mem_q[tail_nx] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* design/utf8_stream_decode_validate_unit.sv */
// Top level of the UTF-8 stream decode and validate unit.
// Uses u8dv_pkg, u8dv_step and u8dv_fifo.
//
//   channel   direction  handshake               payload
//   -------   ---------  ----------------------  ----------------------------
//   input     in         in_valid_i/in_stall_o   in_item_i  (u8dv_pkg::in_item_t)
//   output    out        out_valid_o/out_stall_i out_item_o (u8dv_pkg::out_item_t)
//
// One byte per cycle sustained while the queue has room: a byte lands in the input
// register, is then decoded by the step logic and its zero, one or two results go
// into the result queue, which delivers one result per cycle unless stalled.
// A final byte that also completes a code point gives two results. Reset clears
// the sequence state, the input valid flag and the queue.
// The input stalls only while the queue lacks room for two results.
module utf8_stream_decode_validate_unit #(
  parameter int unsigned FifoDepth = u8dv_pkg::FifoDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  u8dv_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output u8dv_pkg::out_item_t out_item_o
);

  logic                in_valid_q, in_valid_d;
  u8dv_pkg::in_item_t  in_item_q;
  logic                room2;
  logic                fire;
  logic                in_take;
  u8dv_pkg::step_res_t step_res;
  logic [1:0]          push_num;

  // Decode the held byte once the queue can absorb its worst case.
  assign fire       = in_valid_q && room2;
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;
  assign push_num   = fire ? step_res.num : 2'd0;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Hold the payload until the transaction has been decoded.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
  end

  u8dv_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .res_o  (step_res)
  );

  u8dv_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .push0_i     (step_res.res0),
    .push1_i     (step_res.res1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* dv/utf8_stream_decode_validate_unit_tb.sv */
// Self-checking testbench for utf8_stream_decode_validate_unit: directed, random, full queue.
// Depends on u8dv_pkg and the unit's RTL; expected results come from a local decoder model.
`timescale 1ns / 1ps

module utf8_stream_decode_validate_unit_tb;
  import u8dv_pkg::*;

  localparam int ClkHalfNs       = 5;
  localparam int ResetCycles     = 6;
  localparam int LongHoldCycles  = 200;
  // The drain tail covers the input register, the decode stage and the result queue
  localparam int DrainTailCycles = 8;
  localparam int BytesPerPhase   = 250;
  // Watchdog limit on the whole run, above the slowest correct run
  localparam int RunLimitNs      = 2_000_000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  utf8_stream_decode_validate_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Decoder state as the block should hold it
  logic [1:0]  pred_pending = '0;
  logic [2:0]  pred_len     = '0;
  logic [20:0] pred_value   = '0;
  logic        pred_error   = 1'b0;

  // Code points and verdicts still owed by the block, oldest first
  out_item_t   awaited_results[$];
  int          mismatches     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_requests  = 0;
  logic [7:0]  text_buf[$];

  always begin
    #ClkHalfNs clk_i = 1'b1;
    #ClkHalfNs clk_i = 1'b0;
  end

  // Advance the decoder model by one accepted byte and queue the results it owes.
  function automatic void predict_decode(input logic [7:0] b, input logic eos);
    out_item_t   res[$];
    out_item_t   r;
    logic [2:0]  lead_len;
    logic [20:0] floor_cp;
    if (!pred_error) begin
      if (pred_pending == 2'd0) begin
        casez (b)
          8'b0???????: lead_len = 3'd1;
          8'b110?????: lead_len = 3'd2;
          8'b1110????: lead_len = 3'd3;
          8'b11110???: lead_len = 3'd4;
          default:     lead_len = 3'd0;
        endcase
        if (lead_len == 3'd1) begin
          r            = '0;
          r.kind       = KindCodePoint;
          r.code_point = {13'd0, b};
          res.push_back(r);
        end else if (lead_len == 3'd0) begin
          // Stray continuation or 0xF8..0xFF: latch the error
          pred_error = 1'b1;
        end else begin
          pred_len     = lead_len;
          pred_pending = 2'(lead_len - 3'd1);
          pred_value   = {13'd0, b & (8'h7F >> lead_len)};
        end
      end else if (b[7:6] != 2'b10) begin
        // Broken sequence: the byte is not taken as a new lead
        pred_error   = 1'b1;
        pred_pending = '0;
        pred_len     = '0;
        pred_value   = '0;
      end else begin
        pred_value   = {pred_value[14:0], b[5:0]};
        pred_pending = pred_pending - 2'd1;
        if (pred_pending == 2'd0) begin
          case (pred_len)
            3'd2:    floor_cp = MinTwoByte;
            3'd3:    floor_cp = MinThreeByte;
            default: floor_cp = MinFourByte;
          endcase
          if (pred_value > MaxScalar || pred_value < floor_cp ||
              (pred_value >= SurrogateLow && pred_value <= SurrogateHigh)) begin
            pred_error = 1'b1;
          end else begin
            r            = '0;
            r.kind       = KindCodePoint;
            r.code_point = pred_value;
            res.push_back(r);
          end
          pred_len   = '0;
          pred_value = '0;
        end
      end
    end
    if (eos) begin
      r          = '0;
      r.kind     = KindVerdict;
      r.run_last = 1'b1;
      if (pred_error) begin
        r.verdict = VerdictInvalid;
      end else if (pred_pending != 2'd0) begin
        r.verdict       = VerdictTruncated;
        r.missing_bytes = pred_pending;
      end else begin
        r.verdict = VerdictValid;
      end
      res.push_back(r);
      pred_pending = '0;
      pred_len     = '0;
      pred_value   = '0;
      pred_error   = 1'b0;
    end else if (res.size() != 0) begin
      res[res.size() - 1].run_last = 1'b1;
    end
    foreach (res[i]) awaited_results.push_back(res[i]);
  endfunction

  function automatic void check_field(input string name, input logic [20:0] want,
                                      input logic [20:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_output(input out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      $error("result with nothing awaited: kind %0d code_point 0x%0h verdict %0d",
             got.kind, got.code_point, got.verdict);
      mismatches++;
    end else begin
      want = awaited_results.pop_front();
      check_field("kind",          21'(want.kind),          21'(got.kind));
      check_field("code_point",    want.code_point,         got.code_point);
      check_field("verdict",       21'(want.verdict),       21'(got.verdict));
      check_field("missing_bytes", 21'(want.missing_bytes), 21'(got.missing_bytes));
      check_field("run_last",      21'(want.run_last),      21'(got.run_last));
    end
  endfunction

  // Output side: check each transaction, then pick the stall for the next cycle.
  // A long hold request overrides the random stall until hold_left runs out.
  int hold_left   = 0;
  int hold_served = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) compare_output(out_item_o);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one byte, hold it until accepted, then advance the model.
  // Called right after a rising edge; leaves valid high for a following byte.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    in_item_t item;
    item.in_byte       = b;
    item.end_of_string = eos;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_decode(b, eos);
  endtask

  // Send the buffered string, marking its last byte as end of string.
  task automatic send_text();
    foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Drop valid and wait until every awaited result has come out.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainTailCycles) @(posedge clk_i);
  endtask

  // Append the first keep bytes of the len-byte encoding of cp.
  function automatic void append_utf8(input logic [20:0] cp, input int len, input int keep);
    logic [7:0] enc[4];
    enc = '{default: 8'h00};
    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) text_buf.push_back(enc[i]);
  endfunction

  // Build a random string: mostly well-formed symbols, some overlong, surrogate,
  // out of range, bad leads, broken sequences, raw noise and cut-off endings.
  function automatic void make_random_text();
    int          n_sym;
    int          pick;
    int          len;
    int          keep;
    logic [20:0] cp;
    logic [7:0]  b;
    text_buf.delete();
    n_sym = $urandom_range(1, 6);
    for (int s = 0; s < n_sym; s++) begin
      pick = $urandom_range(99);
      len  = 0;
      cp   = '0;
      if (pick < 30) begin
        len = 1; cp = 21'($urandom_range(0, 8'h7F));
      end else if (pick < 50) begin
        len = 2; cp = 21'($urandom_range(21'h80, 21'h7FF));
      end else if (pick < 65) begin
        len = 3; cp = 21'($urandom_range(21'h800, 21'hFFFF));
      end else if (pick < 80) begin
        len = 4; cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      end else if (pick < 84) begin
        // Overlong: value below the floor of its length
        len = $urandom_range(2, 4);
        cp  = 21'($urandom_range(0, (len == 2) ? 21'h7F : (len == 3) ? 21'h7FF : 21'hFFFF));
      end else if (pick < 86) begin
        len = 4; cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
      end else if (pick < 88) begin
        len = 3; cp = 21'($urandom_range(21'hD800, 21'hDFFF));
      end else if (pick < 92) begin
        b = ($urandom_range(1) != 0) ? 8'($urandom_range(8'h80, 8'hBF))
                                     : 8'($urandom_range(8'hF8, 8'hFF));
        text_buf.push_back(b);
      end else if (pick < 96) begin
        // Open a sequence, then break it with a non-continuation byte
        keep = $urandom_range(2, 4);
        append_utf8(21'($urandom_range(0, 21'h1FFFFF)), keep, $urandom_range(1, keep - 1));
        b = 8'($urandom_range(0, 255));
        if (b[7:6] == 2'b10) b = b ^ 8'h40;
        text_buf.push_back(b);
      end else begin
        text_buf.push_back(8'($urandom_range(0, 255)));
      end
      if (len != 0) begin
        keep = len;
        if (s == n_sym - 1 && len > 1 && $urandom_range(9) == 0) keep = $urandom_range(1, len - 1);
        append_utf8(cp, len, keep);
      end
    end
  endfunction

  task automatic run_random_text(input int send_pct, input int stall_pct);
    int sent;
    sent           = 0;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    while (sent < BytesPerPhase) begin
      make_random_text();
      sent += text_buf.size();
      send_text();
    end
    wait_for_drain();
  endtask

  // Field extremes and special cases, back to back with no idling.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Smallest and largest ASCII; final byte completes a code point
    text_buf = '{8'h00, 8'h7F};                send_text();
    // Smallest two-byte value
    text_buf = '{8'hC2, 8'h80};                send_text();
    // Largest scalar value
    text_buf = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};  send_text();
    // Surrogate
    text_buf = '{8'hED, 8'hA0, 8'h80};         send_text();
    // Just above the scalar range
    text_buf = '{8'hF4, 8'h90, 8'h80, 8'h80};  send_text();
    // Overlong through a C1 lead
    text_buf = '{8'hC1, 8'hBF};                send_text();
    // Lone continuation byte as the whole string
    text_buf = '{8'h80};                       send_text();
    // Bad lead, then a byte that must be ignored
    text_buf = '{8'hFF, 8'h41};                send_text();
    // Broken sequence
    text_buf = '{8'hC2, 8'h41};                send_text();
    // Cut-off sequences, three and one bytes missing
    text_buf = '{8'hF0};                       send_text();
    text_buf = '{8'hE2, 8'h82};                send_text();
    wait_for_drain();
  endtask

  task automatic test_random_no_idle();
    run_random_text(0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random_text(57, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random_text(0, 57);
  endtask

  task automatic test_random_both_idle();
    run_random_text(35, 35);
  endtask

  // Hold the output off for a long stretch while bytes keep coming, so the result
  // queue fills and the input stalls; then pause until everything has drained.
  task automatic test_full_queue_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests++;
    for (int k = 0; k < 48; k++) send_byte(8'(8'h20 + k), (k % 8) == 7);
    wait_for_drain();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_full_queue_backpressure();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure
  initial begin
    #RunLimitNs;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* filelist.f */
design/u8dv_pkg.sv
design/u8dv_step.sv
design/u8dv_fifo.sv
design/utf8_stream_decode_validate_unit.sv
dv/utf8_stream_decode_validate_unit_tb.sv
